FILE: design/stlms_pkg.sv
// Package for the sorted table search block.
// Holds field widths, op and status codes, and the default table depth.
// No dependencies.
package stlms_pkg;

    localparam int OP_W                = 2;
    localparam int VALUE_W             = 32;
    localparam int STATUS_W            = 2;
    localparam int POS_W               = 10;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

endpackage

FILE: design/stlms_if.sv
// Valid/ready channel interfaces for the sorted table search block.
// One carries command words in, one carries result words out.
// Depends on stlms_pkg.
interface stlms_in_if;
    logic                                valid;
    logic                                ready;
    logic [stlms_pkg::OP_W-1:0]          op;
    logic signed [stlms_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface stlms_out_if;
    logic                             valid;
    logic                             ready;
    logic [stlms_pkg::STATUS_W-1:0]   status;
    logic [stlms_pkg::POS_W-1:0]      position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);
endinterface

FILE: design/sorted_table_last_match_search.sv
// Sorted table with last-occurrence binary search.
// Append, clear and unused op words are answered from S_IDLE; the result is registered.
// Search runs P probes (up to floor(log2(count)) + 1, 11 for 1024 entries), then
// answers from S_FINISH; each probe is a registered table read and a 32-bit compare.
// Reset (synchronous, active low) empties the table count and the output register;
// table contents stay undefined and are never used before written.
module sorted_table_last_match_search
    #(
        parameter int TABLE_DEPTH = stlms_pkg::DEFAULT_TABLE_DEPTH
    ) (
        input  logic        i_clk,
        input  logic        i_rst_n,
        stlms_in_if.sink    i_in,
        stlms_out_if.source o_out
    );

    import stlms_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_lo, n_lo;
    logic [CW-1:0]              r_hi, n_hi;
    logic [CW-1:0]              r_mid, n_mid;
    logic [CW-1:0]              r_found, n_found;
    logic                       r_hit, n_hit;
    logic signed [VALUE_W-1:0]  r_target, n_target;
    logic                       r_o_valid, n_o_valid;
    t_status                    r_status, n_status;
    logic [POS_W-1:0]           r_position, n_position;

    logic                       in_accept;
    logic                       out_free;
    logic                       full;
    logic                       ram_we;
    logic [AW-1:0]              ram_raddr;
    logic [VALUE_W-1:0]         ram_rdata;
    logic signed [VALUE_W-1:0]  probe;
    logic                       probe_eq;
    logic                       probe_lt;
    logic [CW-1:0]              init_mid;
    logic [CW-1:0]              step_lo;
    logic [CW-1:0]              step_hi;
    logic [CW-1:0]              step_mid;
    logic [CW+POS_W-1:0]        found_ext;

    stlms_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free  = !r_o_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_accept = i_in.valid && i_in.ready;
    assign full      = (r_count == CW'(TABLE_DEPTH));

    assign probe     = $signed(ram_rdata);
    assign probe_eq  = (probe == r_target);
    assign probe_lt  = (probe < r_target);
    assign init_mid  = (r_count - CW'(1)) >> 1;
    assign step_lo   = (probe_eq || probe_lt) ? (r_mid + CW'(1)) : r_lo;
    assign step_hi   = (probe_eq || probe_lt) ? r_hi : r_mid;
    assign step_mid  = step_lo + ((step_hi - step_lo - CW'(1)) >> 1);
    assign ram_raddr = (r_state == S_SEARCH) ? step_mid[AW-1:0] : init_mid[AW-1:0];
    assign found_ext = {{POS_W{1'b0}}, r_found};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_found    = r_found;
        n_hit      = r_hit;
        n_target   = r_target;
        n_o_valid  = r_o_valid && !o_out.ready;
        n_status   = r_status;
        n_position = r_position;
        ram_we     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_position = '0;
                    unique case (i_in.op)
                        OP_APPEND: begin
                            n_o_valid = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_OK;
                                ram_we   = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_o_valid = 1'b1;
                                n_status  = ST_MISSING;
                            end else begin
                                n_lo     = '0;
                                n_hi     = r_count;
                                n_mid    = init_mid;
                                n_hit    = 1'b0;
                                n_found  = '0;
                                n_target = i_in.value;
                                n_state  = S_SEARCH;
                            end
                        end
                        OP_CLEAR: begin
                            n_o_valid = 1'b1;
                            n_status  = ST_OK;
                            n_count   = '0;
                        end
                        default: begin
                            n_o_valid = 1'b1;
                            n_status  = ST_OK;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (probe_eq) begin
                    n_hit   = 1'b1;
                    n_found = r_mid;
                end
                n_lo  = step_lo;
                n_hi  = step_hi;
                n_mid = step_mid;
                if (step_lo >= step_hi) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_status   = r_hit ? ST_FOUND : ST_MISSING;
                    n_position = r_hit ? found_ext[POS_W-1:0] : '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_found    <= n_found;
        r_hit      <= n_hit;
        r_target   <= n_target;
        r_status   <= n_status;
        r_position <= n_position;
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.status   = r_status;
    assign o_out.position = r_position;

endmodule

FILE: design/stlms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
module stlms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/sorted_table_last_match_search_tb.sv
// Testbench for the sorted table last-match search block.
// Drives append, search, clear and unused words, predicts each answer and checks it.
// Depends on stlms_pkg, stlms_if.sv and sorted_table_last_match_search.
module sorted_table_last_match_search_tb;
    import stlms_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_WORDS = 800;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } t_command;

    typedef struct {
        t_status            status;
        logic [POS_W-1:0]   position;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    stlms_in_if  in_if ();
    stlms_out_if out_if ();

    sorted_table_last_match_search #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    t_command    commands_to_send[$];
    t_answer     answers_due[$];
    int          loaded_vals[$];

    logic signed [VALUE_W-1:0] model_entries [0:TABLE_DEPTH-1];
    int          model_count;

    int          words_total;
    int          words_taken;
    int          mismatches;
    t_command    next_cmd;
    t_answer     due;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int send_idle_pct();
        if (words_taken * 3 < words_total)
            return 15;
        else if (words_taken * 3 < words_total * 2)
            return 65;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (words_taken * 3 < words_total)
            return 65;
        else if (words_taken * 3 < words_total * 2)
            return 15;
        return 0;
    endfunction

    task automatic predict_answer(input logic [OP_W-1:0] op,
                                  input logic signed [VALUE_W-1:0] value);
        t_answer a;
        int      low;
        int      high;
        int      mid;
        a.status   = ST_OK;
        a.position = '0;
        case (op)
            OP_APPEND: begin
                if (model_count >= TABLE_DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    model_entries[model_count] = value;
                    model_count++;
                end
            end
            OP_SEARCH: begin
                a.status = ST_MISSING;
                low  = 0;
                high = model_count - 1;
                while (low <= high) begin
                    mid = low + (high - low) / 2;
                    if (model_entries[mid] == value) begin
                        a.status   = ST_FOUND;
                        a.position = mid[POS_W-1:0];
                        low        = mid + 1;
                    end else if (model_entries[mid] < value) begin
                        low = mid + 1;
                    end else begin
                        high = mid - 1;
                    end
                end
            end
            OP_CLEAR: begin
                model_count = 0;
            end
            default: ;
        endcase
        answers_due.push_back(a);
    endtask

    task automatic push_command(input logic [OP_W-1:0] op, input int value);
        t_command c;
        c.op    = op;
        c.value = value;
        commands_to_send.push_back(c);
        if (op == OP_APPEND && loaded_vals.size() < TABLE_DEPTH)
            loaded_vals.push_back(value);
        else if (op == OP_CLEAR)
            loaded_vals.delete();
    endtask

    function automatic int pick_target();
        int sel;
        int idx;
        sel = $urandom_range(0, 99);
        idx = (loaded_vals.size() > 0) ? $urandom_range(0, loaded_vals.size() - 1) : 0;
        if (loaded_vals.size() > 0 && sel < 45)
            return loaded_vals[idx];
        else if (loaded_vals.size() > 0 && sel < 55)
            return loaded_vals[idx] + 1;
        else if (loaded_vals.size() > 0 && sel < 65)
            return loaded_vals[idx] - 1;
        else if (sel < 85)
            return $urandom;
        else if (sel < 92)
            return VAL_MIN;
        return VAL_MAX;
    endfunction

    task automatic append_sorted(input int n);
        longint      cur;
        int unsigned span;
        int          mode;
        mode = $urandom_range(0, 2);
        span = 32'hFFFF_FFFF / (n + 1);
        case (mode)
            0:       cur = longint'($signed($urandom));
            1:       cur = longint'(VAL_MIN) + $urandom_range(0, 3);
            default: cur = longint'($signed($urandom)) / 4;
        endcase
        for (int i = 0; i < n; i++) begin
            if (cur > longint'(VAL_MAX))
                cur = VAL_MAX;
            push_command(OP_APPEND, int'(cur));
            case (mode)
                0:       cur += $urandom_range(0, 2);
                1:       cur += $urandom_range(0, span);
                default: cur += ($urandom_range(0, 3) == 0);
            endcase
        end
    endtask

    task automatic random_noise();
        int sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0:       push_command(OP_UNUSED, $urandom);
            1:       push_command(OP_APPEND, $urandom);
            2:       push_command(OP_SEARCH, pick_target());
            default: push_command(OP_SEARCH, $urandom);
        endcase
    endtask

    task automatic random_session();
        int n;
        int sel;
        push_command(OP_CLEAR, $urandom);
        sel = $urandom_range(0, 99);
        if (sel < 80)
            n = $urandom_range(0, 24);
        else if (sel < 95)
            n = $urandom_range(25, 120);
        else
            n = $urandom_range(121, 400);
        if (commands_to_send.size() + n > RANDOM_WORDS)
            n = RANDOM_WORDS - commands_to_send.size();
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < n; i++)
                push_command(OP_APPEND, $urandom);
        end else begin
            append_sorted(n);
        end
        repeat ($urandom_range(3, 12)) begin
            if ($urandom_range(0, 9) == 0)
                random_noise();
            else
                push_command(OP_SEARCH, pick_target());
        end
    endtask

    task automatic directed_words();
        push_command(OP_SEARCH, 0);
        push_command(OP_UNUSED, 32'hFFFF_FFFF);
        push_command(OP_APPEND, VAL_MIN);
        push_command(OP_APPEND, VAL_MIN);
        push_command(OP_APPEND, -1);
        push_command(OP_APPEND, 0);
        push_command(OP_APPEND, 0);
        push_command(OP_APPEND, 0);
        push_command(OP_APPEND, 1);
        push_command(OP_APPEND, VAL_MAX);
        push_command(OP_APPEND, VAL_MAX);
        push_command(OP_SEARCH, VAL_MIN);
        push_command(OP_SEARCH, -1);
        push_command(OP_SEARCH, 0);
        push_command(OP_SEARCH, VAL_MAX);
        push_command(OP_SEARCH, 2);
        push_command(OP_SEARCH, -2);
        push_command(OP_UNUSED, 32'h5555_5555);
        push_command(OP_SEARCH, 1);
        push_command(OP_CLEAR, 32'hAAAA_AAAA);
        push_command(OP_SEARCH, 0);
        push_command(OP_APPEND, 7);
        push_command(OP_SEARCH, 7);
        push_command(OP_SEARCH, 8);
        push_command(OP_CLEAR, 0);
    endtask

    // Driver: hold a word until taken, predict its answer on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_answer(in_if.op, in_if.value);
                words_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (commands_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    next_cmd = commands_to_send.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.op    <= next_cmd.op;
                    in_if.value <= next_cmd.value;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result status %0d position %0d",
                             $time, out_if.status, out_if.position);
                    mismatches++;
                end else begin
                    due = answers_due.pop_front();
                    if (out_if.status !== due.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, due.status, out_if.status);
                        mismatches++;
                    end
                    if (out_if.position !== due.position) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, due.position, out_if.position);
                        mismatches++;
                    end
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    initial begin
        in_if.valid  = 1'b0;
        in_if.op     = OP_APPEND;
        in_if.value  = '0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        model_count  = 0;
        words_taken  = 0;
        mismatches   = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            model_entries[i] = '0;

        directed_words();
        while (commands_to_send.size() < RANDOM_WORDS)
            random_session();
        words_total = commands_to_send.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (commands_to_send.size() > 0 || in_if.valid || answers_due.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
